### design/imm_pkg.sv
// shared types, constants and helpers for the integer matrix multiply unit
package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;
  localparam int DIM_W      = 4;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int IN_DATA_W  = ((2 * IDX_W + DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * IDX_W + DATA_WIDTH + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_ROWS = 2'd0,
    CFG_A_COLS = 2'd1,
    CFG_B_ROWS = 2'd2,
    CFG_B_COLS = 2'd3
  } cfg_idx_t;

  // controller to datapath
  typedef struct packed {
    logic              ld_a;
    logic              ld_b;
    logic              rd_en;
    logic              first_k;
    logic              last_k;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last_elem;
    logic              err_wr;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_wr;
    logic out_busy;
  } dp_sts_t;

  // largest index in use for a dimension register, out-of-range values clamped
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] r);
    logic [IDX_W-1:0] res;
    if (r == '0) begin
      res = '0;
    end else if (r > DIM_W'(MAX_DIM)) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(r - DIM_W'(1));
    end
    return res;
  endfunction

endpackage

### design/integer_matrix_multiply_unit.sv
// integer matrix multiply unit: top level joining controller and datapath
//
// loads element requests into two 8x8 stores of 32-bit signed values, and on a
// compute request emits C = A * B (A rows by B columns) in row-major order, one
// result request per element, tlast on the final one. loads may follow back to
// back. a compute request runs one multiply-accumulate step per cycle, while it
// reads the a_cols terms of a result, through a single registered-read,
// multiply, accumulate pipeline; each result is those reads, the pipeline fill
// and the hand-over to the output register; each result waits for a free output
// register, so a stalling sink holds it up. no new request is taken while a
// product is in progress. the output register frees the sink side: after the
// final result a new request is accepted while it still waits.
// dimension registers of 0 act as 1 and values above 8 act as 8; if the
// columns of A differ from the rows of B a compute emits one result with
// tuser (size error) set, zero data and tlast. stores have no reset, reading
// an entry never loaded returns undefined data
module integer_matrix_multiply_unit
  import imm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  // request input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // elem_row[2:0], elem_col[5:3], element_value[37:6]
  input  logic [OP_W-1:0]       in_tuser,   // operation[1:0]
  // result output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_row[2:0], out_col[5:3], product_value[37:6]
  output logic                  out_tuser,  // size_error[0]
  output logic                  out_tlast
);

  dp_cmd_t               cmd;
  dp_sts_t               sts;
  logic [IDX_W-1:0]      res_row, res_col;
  logic [DATA_WIDTH-1:0] res_value;

  imm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  // load fields straight from the request payload
  imm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .ld_row    (in_tdata[IDX_W-1:0]),
    .ld_col    (in_tdata[2*IDX_W-1:IDX_W]),
    .ld_value  (in_tdata[2*IDX_W+DATA_WIDTH-1:2*IDX_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_value (res_value),
    .out_err   (out_tuser),
    .out_last  (out_tlast)
  );

  // pack result fields, zero fill to whole bytes
  assign out_tdata = OUT_DATA_W'({res_value, res_col, res_row});

endmodule

### design/imm_ctrl.sv
// controller: configuration registers and element sequencing state machine
module imm_ctrl
  import imm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [OP_W-1:0]      in_op,
  output dp_cmd_t              cmd,
  input  dp_sts_t              sts
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_WAIT_OUT = 5'b00010,
    ST_ISSUE    = 5'b00100,
    ST_DRAIN    = 5'b01000,
    ST_ERR      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0] ar_last, ac_last, br_last, bc_last;
  logic             accept;
  logic             last_elem;

  assign ar_last = dim_last(a_rows_r);
  assign ac_last = dim_last(a_cols_r);
  assign br_last = dim_last(b_rows_r);
  assign bc_last = dim_last(b_cols_r);

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign last_elem = (i_r == ar_last) && (j_r == bc_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(MAX_DIM);
      a_cols_r <= DIM_W'(MAX_DIM);
      b_rows_r <= DIM_W'(MAX_DIM);
      b_cols_r <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A_ROWS: a_rows_r <= cfg_data;
        CFG_A_COLS: a_cols_r <= cfg_data;
        CFG_B_ROWS: b_rows_r <= cfg_data;
        CFG_B_COLS: b_cols_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cmd           = '0;
    cmd.addr_a    = {i_r, k_r};
    cmd.addr_b    = {k_r, j_r};
    cmd.row       = i_r;
    cmd.col       = j_r;
    cmd.last_elem = last_elem;
    cmd.first_k   = (k_r == '0);
    cmd.last_k    = (k_r == ac_last);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_op))
            OP_LOAD_A: cmd.ld_a = 1'b1;
            OP_LOAD_B: cmd.ld_b = 1'b1;
            OP_COMPUTE: begin
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              state_nxt = (ac_last != br_last) ? ST_ERR : ST_WAIT_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_WAIT_OUT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        if (k_r == ac_last) begin
          k_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (sts.res_wr) begin
          if (last_elem) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_WAIT_OUT;
            if (j_r == bc_last) begin
              j_nxt = '0;
              i_nxt = i_r + IDX_W'(1);
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end
        end
      end
      ST_ERR: begin
        if (!sts.out_busy) begin
          cmd.err_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### design/imm_dp.sv
// datapath: element stores, multiply-accumulate pipeline and output register
module imm_dp
  import imm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic [IDX_W-1:0]      ld_row,
  input  logic [IDX_W-1:0]      ld_col,
  input  logic [DATA_WIDTH-1:0] ld_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      out_row,
  output logic [IDX_W-1:0]      out_col,
  output logic [DATA_WIDTH-1:0] out_value,
  output logic                  out_err,
  output logic                  out_last
);

  logic [DATA_WIDTH-1:0] mem_a [DEPTH];
  logic [DATA_WIDTH-1:0] mem_b [DEPTH];

  logic [DATA_WIDTH-1:0] a_q_r, b_q_r, prod_r, acc_r;
  logic [DATA_WIDTH-1:0] sum;
  logic                  v1_r, first1_r, last1_r;
  logic                  v2_r, first2_r, last2_r;
  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_row_r, out_col_r;
  logic [DATA_WIDTH-1:0] out_value_r;
  logic                  out_err_r, out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      mem_a[{ld_row, ld_col}] <= ld_value;
    end
    if (cmd.ld_b) begin
      mem_b[{ld_row, ld_col}] <= ld_value;
    end
    if (cmd.rd_en) begin
      a_q_r <= mem_a[cmd.addr_a];
      b_q_r <= mem_b[cmd.addr_b];
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= cmd.first_k;
    last1_r  <= cmd.last_k;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    prod_r   <= DATA_WIDTH'(a_q_r * b_q_r);
    if (v2_r) begin
      acc_r <= sum;
    end
  end

  assign sum = (first2_r ? '0 : acc_r) + prod_r;

  assign sts.res_wr   = v2_r && last2_r;
  assign sts.out_busy = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sts.res_wr || cmd.err_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.res_wr) begin
      out_row_r   <= cmd.row;
      out_col_r   <= cmd.col;
      out_value_r <= sum;
      out_err_r   <= 1'b0;
      out_last_r  <= cmd.last_elem;
    end else if (cmd.err_wr) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_err_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_err   = out_err_r;
  assign out_last  = out_last_r;

endmodule

### design/imm_chk.sv
// port-level checker for the integer matrix multiply unit, with its bind
module imm_chk
  import imm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result request dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // size error result is zero and last
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("malformed size error result");

  // no request accepted while a product is still in progress
  a_busy_mid_product: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a product");

endmodule

bind integer_matrix_multiply_unit imm_chk u_imm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### verif/integer_matrix_multiply_unit_test.sv
// self-checking testbench for the integer matrix multiply unit
`timescale 1ns / 1ps

module integer_matrix_multiply_unit_test;
  import imm_pkg::*;

  // operation code that the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int LIMIT_CYCLES = 2_000_000;
  // cycles to let pass once nothing is expected
  localparam int DRAIN_CYCLES = 32;
  localparam int ITEM_TARGET  = 350;
  localparam int HOLD_CYCLES  = 400;

  // one request on the input channel
  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic [DATA_WIDTH-1:0] value;
  } mm_request_t;

  // one product element as seen on the result channel
  typedef struct packed {
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic [DATA_WIDTH-1:0] value;
    logic                  err;
    logic                  last;
  } product_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [DIM_W-1:0]      cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // elem_row[2:0], elem_col[5:3], element_value[37:6]
  logic [OP_W-1:0]       in_tuser   = '0;  // operation[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // out_row[2:0], out_col[5:3], product_value[37:6]
  logic                  out_tuser;        // size_error[0]
  logic                  out_tlast;

  integer_matrix_multiply_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // shadow copy of both element stores and of the dimension registers
  logic [DATA_WIDTH-1:0] a_elem [DEPTH];
  logic [DATA_WIDTH-1:0] b_elem [DEPTH];
  bit                    a_loaded [DEPTH];
  bit                    b_loaded [DEPTH];
  logic [DIM_W-1:0]      dim_reg [4];

  product_t expected_products [$];
  int       mismatches    = 0;
  int       requests_sent = 0;
  int       cycle_count   = 0;
  int       burst_left    = 0;

  // receiver state: a long hold-off asked by a test, else a stall pattern of its own
  int sink_hold = 0;
  int sink_mode = 0;
  int sink_left = 0;

  // a register of 0 acts as 1, anything above the store size as the store size
  function automatic int dim_in_use(input logic [DIM_W-1:0] r);
    if (r == '0) return 1;
    if (r > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(r);
  endfunction

  // mirror one accepted request: store a load, or queue the product it causes
  function automatic void predict_request(input mm_request_t req);
    int ar, ac, br, bc, addr;
    logic [DATA_WIDTH-1:0] acc;
    product_t p;
    addr = int'({req.row, req.col});
    case (req.op)
      OP_LOAD_A: begin
        a_elem[addr]   = req.value;
        a_loaded[addr] = 1'b1;
      end
      OP_LOAD_B: begin
        b_elem[addr]   = req.value;
        b_loaded[addr] = 1'b1;
      end
      OP_COMPUTE: begin
        ar = dim_in_use(dim_reg[CFG_A_ROWS]);
        ac = dim_in_use(dim_reg[CFG_A_COLS]);
        br = dim_in_use(dim_reg[CFG_B_ROWS]);
        bc = dim_in_use(dim_reg[CFG_B_COLS]);
        if (ac != br) begin
          // size mismatch: a single flagged result with zero data
          p      = '0;
          p.err  = 1'b1;
          p.last = 1'b1;
          expected_products.push_back(p);
        end else begin
          for (int i = 0; i < ar; i++) begin
            for (int j = 0; j < bc; j++) begin
              acc = '0;
              // products wrap at the data width, as the lhs width truncates them
              for (int k = 0; k < ac; k++)
                acc = acc + a_elem[i * MAX_DIM + k] * b_elem[k * MAX_DIM + j];
              p.row   = IDX_W'(i);
              p.col   = IDX_W'(j);
              p.value = acc;
              p.err   = 1'b0;
              p.last  = (i == ar - 1) && (j == bc - 1);
              expected_products.push_back(p);
            end
          end
        end
      end
      default: ;  // unused operation changes nothing
    endcase
  endfunction

  function automatic mm_request_t mk_request(input logic [OP_W-1:0] op, input int row,
                                             input int col, input logic [DATA_WIDTH-1:0] value);
    mm_request_t r;
    r.op    = op;
    r.row   = IDX_W'(row);
    r.col   = IDX_W'(col);
    r.value = value;
    return r;
  endfunction

  // element values lean towards the corners of the signed range
  function automatic logic [DATA_WIDTH-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return DATA_WIDTH'($urandom_range(0, 31)) - DATA_WIDTH'(16);
      default: return $urandom();
    endcase
  endfunction

  // mostly small sizes, now and then the clamped values at either end
  function automatic logic [DIM_W-1:0] rand_dim();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return DIM_W'($urandom_range(1, 3));
    if (pick < 15) return DIM_W'($urandom_range(4, 8));
    if (pick < 17) return '0;
    return DIM_W'($urandom_range(9, 15));
  endfunction

  function automatic void report_mismatch(input string what, input product_t want,
                                          input product_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected row %0d col %0d value %h err %b last %b",
               $time, what, want.row, want.col, want.value, want.err, want.last);
      $display("%0t: %s: got row %0d col %0d value %h err %b last %b",
               $time, what, got.row, got.col, got.value, got.err, got.last);
    end
  endfunction

  // offer one request, in bursts with random gaps, and mirror it once taken
  task automatic send_request(input mm_request_t req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req.op;
    in_tdata  <= IN_DATA_W'({req.value, req.col, req.row});
    do @(posedge clk); while (!in_tready);
    predict_request(req);
    if (req.op != OP_UNUSED) requests_sent++;
  endtask

  // stop sending and let every expected result come out, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (expected_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(input cfg_idx_t idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    dim_reg[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic set_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                          input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
    wait_idle();
    write_dim(CFG_A_ROWS, ar);
    write_dim(CFG_A_COLS, ac);
    write_dim(CFG_B_ROWS, br);
    write_dim(CFG_B_COLS, bc);
  endtask

  // load every entry that the next compute reads and that was never written
  task automatic load_missing();
    int ar, ac, bc;
    ar = dim_in_use(dim_reg[CFG_A_ROWS]);
    ac = dim_in_use(dim_reg[CFG_A_COLS]);
    bc = dim_in_use(dim_reg[CFG_B_COLS]);
    if (ac != dim_in_use(dim_reg[CFG_B_ROWS])) return;
    for (int i = 0; i < ar; i++)
      for (int k = 0; k < ac; k++)
        if (!a_loaded[i * MAX_DIM + k])
          send_request(mk_request(OP_LOAD_A, i, k, rand_element()));
    for (int k = 0; k < ac; k++)
      for (int j = 0; j < bc; j++)
        if (!b_loaded[k * MAX_DIM + j])
          send_request(mk_request(OP_LOAD_B, k, j, rand_element()));
  endtask

  // a load mostly inside the region in use, sometimes anywhere in the store
  task automatic send_random_load();
    int rows, cols;
    logic [OP_W-1:0] op;
    op = ($urandom_range(0, 1) != 0) ? OP_LOAD_B : OP_LOAD_A;
    if (op == OP_LOAD_A) begin
      rows = dim_in_use(dim_reg[CFG_A_ROWS]);
      cols = dim_in_use(dim_reg[CFG_A_COLS]);
    end else begin
      rows = dim_in_use(dim_reg[CFG_B_ROWS]);
      cols = dim_in_use(dim_reg[CFG_B_COLS]);
    end
    if ($urandom_range(0, 3) == 0) begin
      rows = MAX_DIM;
      cols = MAX_DIM;
    end
    send_request(mk_request(op, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                            rand_element()));
  endtask

  task automatic send_compute();
    send_request(mk_request(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom()));
  endtask

  // 1x1 products at the signed extremes, where the sum wraps
  task automatic test_single_element();
    set_dims(4'd1, 4'd1, 4'd1, 4'd1);
    send_request(mk_request(OP_LOAD_A, 0, 0, 32'h7FFF_FFFF));
    send_request(mk_request(OP_LOAD_B, 0, 0, 32'h7FFF_FFFF));
    send_compute();
    send_request(mk_request(OP_LOAD_A, 0, 0, 32'h8000_0000));
    send_request(mk_request(OP_LOAD_B, 0, 0, 32'hFFFF_FFFF));
    send_compute();
    // highest indices, outside the region in use
    send_request(mk_request(OP_LOAD_A, 7, 7, 32'hFFFF_FFFF));
    send_request(mk_request(OP_LOAD_B, 7, 7, 32'h0000_0000));
    send_compute();
  endtask

  // operation 3 must leave the stores alone and produce nothing
  task automatic test_unused_operation();
    send_request(mk_request(OP_UNUSED, 0, 0, 32'h1234_5678));
    send_request(mk_request(OP_UNUSED, 7, 7, 32'hFFFF_FFFF));
    send_compute();
  endtask

  // zero registers act as one
  task automatic test_zero_dims();
    set_dims(4'd0, 4'd0, 4'd0, 4'd0);
    send_compute();
  endtask

  // inner sizes that differ give one flagged result, also after clamping
  task automatic test_size_mismatch();
    set_dims(4'd1, 4'd2, 4'd3, 4'd1);
    send_compute();
    set_dims(4'd8, 4'd15, 4'd2, 4'd8);
    send_compute();
  endtask

  // a_cols 0 against b_rows 1 counts as a match after clamping
  task automatic test_zero_against_one();
    set_dims(4'd2, 4'd0, 4'd1, 4'd2);
    send_request(mk_request(OP_LOAD_A, 1, 0, 32'h8000_0000));
    send_request(mk_request(OP_LOAD_B, 0, 1, 32'h0000_0002));
    load_missing();
    send_compute();
  endtask

  // full 8x8 product, a_cols and b_cols above the store size clamp to 8
  task automatic test_full_size();
    set_dims(4'd8, 4'd15, 4'd8, 4'd9);
    for (int i = 0; i < MAX_DIM; i++) begin
      for (int j = 0; j < MAX_DIM; j++) begin
        send_request(mk_request(OP_LOAD_A, i, j, rand_element()));
        send_request(mk_request(OP_LOAD_B, i, j, rand_element()));
      end
    end
    send_compute();
    send_request(mk_request(OP_LOAD_A, 0, 0, 32'h8000_0000));
    send_request(mk_request(OP_LOAD_B, 7, 7, 32'h7FFF_FFFF));
    send_compute();
  endtask

  // sink holds off long enough that the block fills up and stalls its input
  task automatic test_backpressure();
    set_dims(4'd2, 4'd2, 4'd2, 4'd2);
    load_missing();
    sink_hold = HOLD_CYCLES;
    repeat (3) send_compute();
    repeat (4) send_random_load();
    send_compute();
    // sender waits for the last result before going on
    wait_idle();
  endtask

  // random settings, each phase a few load-then-compute sequences with some noise
  task automatic test_random_phases();
    logic [DIM_W-1:0] ar, ac, br, bc;
    while (requests_sent < ITEM_TARGET) begin
      ar = rand_dim();
      ac = rand_dim();
      br = rand_dim();
      bc = rand_dim();
      // mostly matching inner sizes, the rest may give size errors
      if ($urandom_range(0, 4) != 0) br = ac;
      set_dims(ar, ac, br, bc);
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 6)) send_random_load();
        if ($urandom_range(0, 7) == 0)
          send_request(mk_request(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                  $urandom()));
        load_missing();
        send_compute();
      end
    end
  endtask

  // receiver: long hold-off when asked, otherwise ready, random or mostly stalled
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold  = sink_hold - 1;
    end else begin
      if (sink_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        sink_left = $urandom_range(16, 160);
      end
      sink_left = sink_left - 1;
      case (sink_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // each accepted result against the oldest expectation
  always @(posedge clk) begin : check_result
    product_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.row   = out_tdata[IDX_W-1:0];
      got.col   = out_tdata[2*IDX_W-1:IDX_W];
      got.value = out_tdata[2*IDX_W+DATA_WIDTH-1:2*IDX_W];
      got.err   = out_tuser;
      got.last  = out_tlast;
      if (expected_products.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_products.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
    end
  end

  // guard against a hung block
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // register values after reset
    for (int n = 0; n < 4; n++) dim_reg[n] = DIM_W'(MAX_DIM);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_unused_operation();
    test_zero_dims();
    test_size_mismatch();
    test_zero_against_one();
    test_full_size();
    test_backpressure();
    test_random_phases();

    // drain and watch for stray results
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
